[hdl/fmf_pkg.sv]
package fmf_pkg;

    localparam int HIST_STEPS = 32;
    localparam int ELEMENTS   = 1024;

    localparam int DATA_W    = 32;
    localparam int ORDER_W   = 15;
    localparam int STEP_W    = 6;
    localparam int ELEM_W    = 11;
    localparam int SLOT_W    = 5;
    localparam int POS_W     = 10;
    localparam int HIST_AW   = SLOT_W + POS_W;
    localparam int CFG_IDX_W = 4;

    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 54;
    localparam int NUM_W     = 21;
    localparam int DIV_W     = 40;
    localparam int DIV_CNT_W = 6;
    localparam int SCALED_W  = 48;
    localparam int TOTAL_W   = 86;
    localparam int RES_W     = 50;

    localparam logic [ORDER_W-1:0] ORDER_DEFAULT = 15'd8192;
    localparam logic [STEP_W-1:0]  STEPS_MAX     = 6'd32;
    localparam logic [ELEM_W-1:0]  ELEMS_MAX     = 11'd1024;
    localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMS = 4'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered_value;
        logic [POS_W-1:0]         element_position;
    } t_out_item;

    typedef enum logic [3:0] {
        S_BUILD_INIT,
        S_BUILD_MUL,
        S_BUILD_PREP,
        S_BUILD_DIV,
        S_BUILD_WRITE,
        S_IDLE,
        S_TAP_READ,
        S_TAP_MUL,
        S_TAP_ACC,
        S_SCALE_PREP,
        S_SCALE_LO,
        S_SCALE_HI,
        S_SCALE_SUM,
        S_FINISH
    } t_state;

endpackage

[hdl/fractional_memory_filter_top.sv]
// Per-element Grunwald-Letnikov memory filter. Each item carries one field
// element; the element index counts up within a time step and the item flagged
// last (or the one at position elements_in_use-1) closes the step. The sample
// is stored in that element's history ring, then the result is
// sample + scale * sum_j c_j * history[n-j] over the filled depth,
// rounded and saturated to Q16.16, tagged with the element position.
// One 33x33 multiplier serves everything under a small sequencer, and the
// history sits in a single RAM with one read port, so an item walks its fill
// taps in turn (fill = taps in use, at most steps_in_use), each read, multiplied
// and accumulated, then scales the sum (prepare, low product, high product,
// sum) and loads the output register once that is free. Input stall stays
// high while an item is in work. After reset and after every write to one of
// the four configuration registers the coefficient table is rebuilt by the
// same multiplier and a bit-serial divider, during which input stall is high.
// Writing steps_in_use or elements_in_use with a new effective value restarts
// the history. Write configuration only while the block is idle.
module fractional_memory_filter_top
    import fmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    // Sequencer and configuration
    t_state                   r_state, n_state;
    logic [ORDER_W-1:0]       r_order, n_order;
    logic signed [DATA_W-1:0] r_scale, n_scale;
    logic [STEP_W-1:0]        r_steps, n_steps;
    logic [ELEM_W-1:0]        r_elems, n_elems;

    // History bookkeeping
    logic [SLOT_W-1:0]        r_newest, n_newest;
    logic [STEP_W-1:0]        r_filled, n_filled;
    logic [POS_W-1:0]         r_counter, n_counter;

    // Item in work
    logic signed [DATA_W-1:0] r_sample, n_sample;
    logic                     r_last, n_last;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [STEP_W-1:0]        r_fill, n_fill;
    logic [SLOT_W-1:0]        r_idx, n_idx;
    logic [STEP_W-1:0]        r_j, n_j;
    logic signed [ACC_W-1:0]  r_acc, n_acc;

    // Shared multiplier and scaling
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [ACC_W-2:0]         r_amag, n_amag;
    logic [DATA_W-1:0]        r_smag, n_smag;
    logic                     r_neg, n_neg;
    logic [63:0]              r_plo, n_plo;
    logic [SCALED_W-1:0]      r_scaled, n_scaled;

    // Coefficient build
    logic signed [DATA_W-1:0] r_prev, n_prev;
    logic [DIV_W-1:0]         r_dvd, n_dvd;
    logic [STEP_W-1:0]        r_rem, n_rem;
    logic [DIV_CNT_W-1:0]     r_cnt, n_cnt;

    // Output register
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;

    // Memory ports
    logic                     hist_we;
    logic [HIST_AW-1:0]       hist_waddr, hist_raddr;
    logic [DATA_W-1:0]        hist_rdata;
    logic                     coef_we;
    logic [SLOT_W-1:0]        coef_waddr;
    logic [DATA_W-1:0]        coef_wdata, coef_rdata;

    logic signed [MUL_W-1:0]  mul_a, mul_b;

    fmf_ram #(.WIDTH(DATA_W), .DEPTH(HIST_STEPS * ELEMENTS)) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_we),
        .i_wr_addr (hist_waddr),
        .i_wr_data (i_in_data.sample_value),
        .i_rd_addr (hist_raddr),
        .o_rd_data (hist_rdata)
    );

    fmf_ram #(.WIDTH(DATA_W), .DEPTH(HIST_STEPS)) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (coef_we),
        .i_wr_addr (coef_waddr),
        .i_wr_data (coef_wdata),
        .i_rd_addr (r_j[SLOT_W-1:0]),
        .o_rd_data (coef_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BUILD_INIT;
            r_order     <= ORDER_DEFAULT;
            r_scale     <= '0;
            r_steps     <= STEPS_MAX;
            r_elems     <= ELEMS_MAX;
            r_newest    <= '0;
            r_filled    <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
            r_j         <= '0;
        end else begin
            r_state     <= n_state;
            r_order     <= n_order;
            r_scale     <= n_scale;
            r_steps     <= n_steps;
            r_elems     <= n_elems;
            r_newest    <= n_newest;
            r_filled    <= n_filled;
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
            r_j         <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_last   <= n_last;
        r_pos    <= n_pos;
        r_slot   <= n_slot;
        r_fill   <= n_fill;
        r_idx    <= n_idx;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_amag   <= n_amag;
        r_smag   <= n_smag;
        r_neg    <= n_neg;
        r_plo    <= n_plo;
        r_scaled <= n_scaled;
        r_prev   <= n_prev;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

    // Item position, ring slot and depth for the next accepted item
    logic [POS_W-1:0]  pos_c;
    logic [SLOT_W-1:0] slot0_c, slot_c;
    logic [STEP_W-1:0] fill_c;

    always_comb begin
        pos_c   = ({1'b0, r_counter} >= r_elems) ? '0 : r_counter;
        slot0_c = ({1'b0, r_newest} < r_steps) ? r_newest : '0;
        slot_c  = (slot0_c == '0) ? SLOT_W'(r_steps - 6'd1) : slot0_c - 5'd1;
        fill_c  = (r_filled < r_steps) ? r_filled + 6'd1 : r_steps;
    end

    // Datapath helpers
    logic signed [NUM_W-1:0]  num;
    logic [55:0]              pmag;
    logic [55:0]              xsum;
    logic [STEP_W:0]          rem_sh;
    logic                     qbit;
    logic signed [DATA_W-1:0] coef_sat;
    logic [63:0]              tmag;
    logic [47:0]              tround;
    logic [TOTAL_W-1:0]       total;
    logic signed [RES_W-1:0]  res_sum;
    logic signed [DATA_W-1:0] res_sat;
    logic                     step_end;
    logic [ORDER_W-1:0]       cfg_order;
    logic [STEP_W-1:0]        cfg_steps;
    logic [ELEM_W-1:0]        cfg_elems;

    always_comb begin
        num = $signed({2'b00, SLOT_W'(r_j - 6'd1), 14'd0}) -
              $signed({6'd0, r_order});
        pmag = r_prod[PROD_W-1] ? 56'(-r_prod[55:0]) : r_prod[55:0];
        xsum = pmag + {37'd0, r_j, 13'd0};
        rem_sh = {r_rem, r_dvd[DIV_W-1]};
        qbit = (rem_sh >= {1'b0, r_j});
        if (!r_neg) begin
            coef_sat = (r_dvd > {{(DIV_W-DATA_W){1'b0}}, SAT_MAX}) ? SAT_MAX
                                                                  : r_dvd[DATA_W-1:0];
        end else begin
            coef_sat = (r_dvd > {{(DIV_W-DATA_W){1'b0}}, SAT_MIN}) ? SAT_MIN
                                                                  : -r_dvd[DATA_W-1:0];
        end
        tmag   = r_prod[63] ? 64'(-r_prod[63:0]) : r_prod[63:0];
        tround = 48'((tmag + 64'd32768) >> 16);
        total  = {r_prod[53:0], 32'd0} + {22'd0, r_plo} + (TOTAL_W'(1) << 37);
        res_sum = r_neg ? $signed(RES_W'(r_sample)) - $signed({2'b00, r_scaled})
                        : $signed(RES_W'(r_sample)) + $signed({2'b00, r_scaled});
        if (res_sum > $signed(RES_W'(SAT_MAX))) begin
            res_sat = SAT_MAX;
        end else if (res_sum < $signed(RES_W'(SAT_MIN))) begin
            res_sat = SAT_MIN;
        end else begin
            res_sat = res_sum[DATA_W-1:0];
        end
        step_end = r_last || (({1'b0, r_pos} + 11'd1) >= r_elems);
        cfg_order = (i_cfg_data[ORDER_W-1:0] == '0) ? ORDER_DEFAULT
                                                    : i_cfg_data[ORDER_W-1:0];
        cfg_steps = ((i_cfg_data[STEP_W-1:0] == '0) ||
                     (i_cfg_data[STEP_W-1:0] > STEPS_MAX)) ? STEPS_MAX
                                                           : i_cfg_data[STEP_W-1:0];
        cfg_elems = ((i_cfg_data[ELEM_W-1:0] == '0) ||
                     (i_cfg_data[ELEM_W-1:0] > ELEMS_MAX)) ? ELEMS_MAX
                                                           : i_cfg_data[ELEM_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_order     = r_order;
        n_scale     = r_scale;
        n_steps     = r_steps;
        n_elems     = r_elems;
        n_newest    = r_newest;
        n_filled    = r_filled;
        n_counter   = r_counter;
        n_sample    = r_sample;
        n_last      = r_last;
        n_pos       = r_pos;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_j         = r_j;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_amag      = r_amag;
        n_smag      = r_smag;
        n_neg       = r_neg;
        n_plo       = r_plo;
        n_scaled    = r_scaled;
        n_prev      = r_prev;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        hist_we    = 1'b0;
        hist_waddr = {slot_c, pos_c};
        hist_raddr = {r_idx, r_pos};
        coef_we    = 1'b0;
        coef_waddr = r_j[SLOT_W-1:0];
        coef_wdata = coef_sat;
        mul_a      = MUL_W'(r_prev);
        mul_b      = MUL_W'(num);

        case (r_state)
            S_BUILD_INIT: begin
                coef_we    = 1'b1;
                coef_waddr = '0;
                coef_wdata = ONE_Q30;
                n_prev     = ONE_Q30;
                n_j        = 6'd1;
                n_state    = (r_steps == 6'd1) ? S_IDLE : S_BUILD_MUL;
            end
            S_BUILD_MUL: begin
                n_prod  = mul_a * mul_b;
                n_state = S_BUILD_PREP;
            end
            S_BUILD_PREP: begin
                n_neg   = r_prod[PROD_W-1];
                n_dvd   = xsum[53:14];
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_BUILD_DIV;
            end
            S_BUILD_DIV: begin
                // Restoring divide by j, one quotient bit a cycle
                n_dvd = {r_dvd[DIV_W-2:0], qbit};
                n_rem = qbit ? STEP_W'(rem_sh - {1'b0, r_j}) : rem_sh[STEP_W-1:0];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    n_state = S_BUILD_WRITE;
                end
            end
            S_BUILD_WRITE: begin
                coef_we = 1'b1;
                n_prev  = coef_sat;
                n_j     = r_j + 6'd1;
                n_state = ((r_j + 6'd1) == r_steps) ? S_IDLE : S_BUILD_MUL;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    hist_we  = 1'b1;
                    n_sample = i_in_data.sample_value;
                    n_last   = i_in_data.last_element;
                    n_pos    = pos_c;
                    n_slot   = slot_c;
                    n_fill   = fill_c;
                    n_idx    = slot_c;
                    n_j      = '0;
                    n_acc    = '0;
                    n_state  = S_TAP_READ;
                end
            end
            S_TAP_READ: begin
                n_state = S_TAP_MUL;
            end
            S_TAP_MUL: begin
                mul_a   = MUL_W'($signed(coef_rdata));
                mul_b   = MUL_W'($signed(hist_rdata));
                n_prod  = mul_a * mul_b;
                n_state = S_TAP_ACC;
            end
            S_TAP_ACC: begin
                // Round the tap to Q.30 half away from zero, then sum
                n_acc = r_prod[63] ? r_acc - $signed({6'd0, tround})
                                   : r_acc + $signed({6'd0, tround});
                n_j   = r_j + 6'd1;
                n_idx = ({1'b0, r_idx} == (r_steps - 6'd1)) ? '0 : r_idx + 5'd1;
                n_state = ((r_j + 6'd1) == r_fill) ? S_SCALE_PREP : S_TAP_READ;
            end
            S_SCALE_PREP: begin
                n_amag  = r_acc[ACC_W-1] ? (ACC_W-1)'(-r_acc) : r_acc[ACC_W-2:0];
                n_smag  = r_scale[DATA_W-1] ? -r_scale : r_scale;
                n_neg   = r_acc[ACC_W-1] != r_scale[DATA_W-1];
                n_state = S_SCALE_LO;
            end
            S_SCALE_LO: begin
                mul_a   = {1'b0, r_amag[31:0]};
                mul_b   = {1'b0, r_smag};
                n_prod  = mul_a * mul_b;
                n_state = S_SCALE_HI;
            end
            S_SCALE_HI: begin
                mul_a   = {12'd0, r_amag[ACC_W-2:32]};
                mul_b   = {1'b0, r_smag};
                n_plo   = r_prod[63:0];
                n_prod  = mul_a * mul_b;
                n_state = S_SCALE_SUM;
            end
            S_SCALE_SUM: begin
                n_scaled = total[38 +: SCALED_W];
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                // Load the result once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out.filtered_value   = res_sat;
                    n_out.element_position = r_pos;
                    if (step_end) begin
                        n_newest  = r_slot;
                        n_filled  = r_fill;
                        n_counter = '0;
                    end else begin
                        n_counter = r_pos + 10'd1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Configuration writes: update, restart history on a new geometry,
        // and rebuild the coefficient table
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ORDER: begin
                    n_order = cfg_order;
                    n_state = S_BUILD_INIT;
                end
                REG_SCALE: begin
                    n_scale = i_cfg_data;
                    n_state = S_BUILD_INIT;
                end
                REG_STEPS: begin
                    n_steps = cfg_steps;
                    if (cfg_steps != r_steps) begin
                        n_newest  = '0;
                        n_filled  = '0;
                        n_counter = '0;
                    end
                    n_state = S_BUILD_INIT;
                end
                REG_ELEMS: begin
                    n_elems = cfg_elems;
                    if (cfg_elems != r_elems) begin
                        n_newest  = '0;
                        n_filled  = '0;
                        n_counter = '0;
                    end
                    n_state = S_BUILD_INIT;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The filled depth never runs past the depth in use
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= r_steps)
        else $error("filled depth exceeds depth in use");

    // The newest slot stays inside the ring
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_newest} < r_steps)
        else $error("newest slot outside ring");

    // An accepted item closes the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_cfg_wr_en) |=> o_in_stall)
        else $error("input reopened right after accept");

    // Tap walk never passes the depth of the item
    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP_READ || r_state == S_TAP_MUL || r_state == S_TAP_ACC)
        |-> (r_j < r_fill))
        else $error("tap index beyond fill");

endmodule

[hdl/fmf_ram.sv]
module fmf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
